### hdl/srjb_pkg.sv
package srjb_pkg;

    // buffer sizing
    localparam int DEPTH        = 5;
    localparam int SLOTS        = DEPTH + 1;
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int HEADER_BYTES = 16;

    // field widths
    localparam int SEQ_W   = 32;
    localparam int STAMP_W = 32;
    localparam int TAG_W   = 16;
    localparam int BYTES_W = 16;
    localparam int KIND_W  = 8;

    // header kind for audio packets
    localparam logic [KIND_W-1:0] KIND_AUDIO = 8'h01;

    // request codes
    localparam logic REQ_PACKET  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [SEQ_W-1:0]   t_seq;
    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [TAG_W-1:0]   t_tag;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic insert;
        logic clear_last;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic restart;
        logic drop;
        logic can_inorder;
        logic can_force;
        logic last_one;
    } t_stat;

endpackage

### hdl/srjb_if.sv
interface srjb_in_if;
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [15:0]             packet_bytes;
    logic [7:0]              packet_kind;
    logic [31:0]             seq_number;
    logic [31:0]             stamp;
    logic [15:0]             payload_tag;

    modport source (
        output valid, req_type, packet_bytes, packet_kind, seq_number, stamp, payload_tag,
        input  ready
    );
    modport sink (
        input  valid, req_type, packet_bytes, packet_kind, seq_number, stamp, payload_tag,
        output ready
    );
endinterface

interface srjb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_seq;
    logic [31:0] out_stamp;
    logic [15:0] out_payload_tag;
    logic        forced;
    logic        last_of_run;

    modport source (
        output valid, out_seq, out_stamp, out_payload_tag, forced, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_seq, out_stamp, out_payload_tag, forced, last_of_run,
        output ready
    );
endinterface

### hdl/sequence_reorder_jitter_buffer.sv
// Reorders audio packet descriptors by sequence number.
// Input channel i_in carries one request per item: a received packet
// (header length, kind byte, sequence, timestamp, payload tag) or a
// session restart. Output channel o_out carries released descriptors,
// each flagged as forced (overflow flush) or in order, with last_of_run
// marking the final release caused by one input item.
// Short, wrong-kind and stale packets are dropped with no result; a
// restart clears the last released sequence and keeps the buffer.
// Steps: the accept, then a check-and-insert step, where a drop or a
// restart ends. A kept packet then goes to the release state, which
// releases up to six results in turn, or finds none to release, and
// then returns to idle. The sorted insert into the six-entry register
// row is done in the insert step; the single output register gives
// one release per cycle while the receiver takes each result.
// Only one item is in work at a time: i_in.ready is high only while idle,
// which includes while the last result still waits in the output register.
// A stalled receiver holds the release run; no result is lost.
// Reset (synchronous, active low) empties the buffer and clears the last
// released sequence.
module sequence_reorder_jitter_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srjb_in_if.sink     i_in,
    srjb_out_if.source  o_out
);

    srjb_pkg::t_cmd  w_cmd;
    srjb_pkg::t_stat w_stat;

    srjb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    srjb_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_type        (i_in.req_type),
        .i_packet_bytes    (i_in.packet_bytes),
        .i_packet_kind     (i_in.packet_kind),
        .i_seq_number      (i_in.seq_number),
        .i_stamp           (i_in.stamp),
        .i_payload_tag     (i_in.payload_tag),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_out_seq         (o_out.out_seq),
        .o_out_stamp       (o_out.out_stamp),
        .o_out_payload_tag (o_out.out_payload_tag),
        .o_forced          (o_out.forced),
        .o_last_of_run     (o_out.last_of_run)
    );

    // a release only happens when a release rule holds
    a_emit_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (w_stat.can_inorder || w_stat.can_force))
        else $error("release without cause");

    // a release never overwrites an item the receiver has not taken
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out.valid || o_out.ready))
        else $error("output item overwritten");

    // a forced release always ends the run
    a_forced_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.forced) |-> o_out.last_of_run)
        else $error("forced release not last of run");

    // one item at a time: no accept right after an accept
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while another is in work");

endmodule

### hdl/srjb_datapath.sv
module srjb_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_type,
    input  logic [15:0]           i_packet_bytes,
    input  logic [7:0]            i_packet_kind,
    input  logic [31:0]           i_seq_number,
    input  logic [31:0]           i_stamp,
    input  logic [15:0]           i_payload_tag,
    input  srjb_pkg::t_cmd        i_cmd,
    output srjb_pkg::t_stat       o_stat,
    output logic [31:0]           o_out_seq,
    output logic [31:0]           o_out_stamp,
    output logic [15:0]           o_out_payload_tag,
    output logic                  o_forced,
    output logic                  o_last_of_run
);

    // sorted entry row, head at index 0
    srjb_pkg::t_seq   r_seq   [srjb_pkg::SLOTS];
    srjb_pkg::t_stamp r_stamp [srjb_pkg::SLOTS];
    srjb_pkg::t_tag   r_tag   [srjb_pkg::SLOTS];
    srjb_pkg::t_count r_count;
    srjb_pkg::t_seq   r_last;

    // latched input item
    logic                          r_in_req;
    logic [srjb_pkg::BYTES_W-1:0]  r_in_bytes;
    logic [srjb_pkg::KIND_W-1:0]   r_in_kind;
    srjb_pkg::t_seq                r_in_seq;
    srjb_pkg::t_stamp              r_in_stamp;
    srjb_pkg::t_tag                r_in_tag;

    // output item register
    srjb_pkg::t_seq   r_out_seq;
    srjb_pkg::t_stamp r_out_stamp;
    srjb_pkg::t_tag   r_out_tag;
    logic             r_out_forced;
    logic             r_out_last;

    logic [srjb_pkg::SLOTS-1:0] w_gt;
    logic                       w_inorder;
    logic                       w_force;
    logic                       w_more;

    // entries greater than the new sequence, a suffix of the valid ones
    always_comb begin
        for (int i = 0; i < srjb_pkg::SLOTS; i++) begin
            w_gt[i] = (srjb_pkg::t_count'(i) < r_count) && (r_seq[i] > r_in_seq);
        end
    end

    // release decisions and lookahead for the end of the run
    always_comb begin
        w_inorder = (r_count != '0) &&
                    ((r_last == '0) || (r_seq[0] == r_last + srjb_pkg::t_seq'(1)));
        w_force   = r_count > srjb_pkg::t_count'(srjb_pkg::DEPTH);
        w_more    = ((r_count > srjb_pkg::t_count'(1)) &&
                     ((r_seq[0] == '0) || (r_seq[1] == r_seq[0] + srjb_pkg::t_seq'(1)))) ||
                    (r_count > srjb_pkg::t_count'(srjb_pkg::SLOTS));
    end

    assign o_stat.restart     = (r_in_req == srjb_pkg::REQ_RESTART);
    assign o_stat.drop        = (r_in_bytes < srjb_pkg::BYTES_W'(srjb_pkg::HEADER_BYTES)) ||
                                (r_in_kind != srjb_pkg::KIND_AUDIO) ||
                                (r_in_seq < r_last);
    assign o_stat.can_inorder = w_inorder;
    assign o_stat.can_force   = w_force;
    assign o_stat.last_one    = !w_inorder || !w_more;

    // input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_req   <= i_req_type;
            r_in_bytes <= i_packet_bytes;
            r_in_kind  <= i_packet_kind;
            r_in_seq   <= i_seq_number;
            r_in_stamp <= i_stamp;
            r_in_tag   <= i_payload_tag;
        end
    end

    // entry row: sorted insert or head release
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            for (int i = 0; i < srjb_pkg::SLOTS; i++) begin
                if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                    r_seq[i]   <= r_seq[(i > 0) ? i - 1 : 0];
                    r_stamp[i] <= r_stamp[(i > 0) ? i - 1 : 0];
                    r_tag[i]   <= r_tag[(i > 0) ? i - 1 : 0];
                end else if (w_gt[i] || srjb_pkg::t_count'(i) == r_count) begin
                    r_seq[i]   <= r_in_seq;
                    r_stamp[i] <= r_in_stamp;
                    r_tag[i]   <= r_in_tag;
                end
            end
        end else if (i_cmd.emit) begin
            for (int i = 0; i < srjb_pkg::SLOTS - 1; i++) begin
                r_seq[i]   <= r_seq[i + 1];
                r_stamp[i] <= r_stamp[i + 1];
                r_tag[i]   <= r_tag[i + 1];
            end
        end
    end

    // fill count and last released sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_count <= r_count + srjb_pkg::t_count'(1);
            end else if (i_cmd.emit) begin
                r_count <= r_count - srjb_pkg::t_count'(1);
            end
            if (i_cmd.clear_last) begin
                r_last <= '0;
            end else if (i_cmd.emit) begin
                r_last <= r_seq[0];
            end
        end
    end

    // output item register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_seq    <= r_seq[0];
            r_out_stamp  <= r_stamp[0];
            r_out_tag    <= r_tag[0];
            r_out_forced <= !w_inorder;
            r_out_last   <= !w_inorder || !w_more;
        end
    end

    assign o_out_seq         = r_out_seq;
    assign o_out_stamp       = r_out_stamp;
    assign o_out_payload_tag = r_out_tag;
    assign o_forced          = r_out_forced;
    assign o_last_of_run     = r_out_last;

endmodule

### hdl/srjb_ctrl.sv
module srjb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  srjb_pkg::t_stat i_stat,
    output srjb_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_INSERT  = 2'd1;
    localparam logic [1:0] ST_RELEASE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (i_stat.restart) begin
                    o_cmd.clear_last = 1'b1;
                    n_state          = ST_IDLE;
                end else if (i_stat.drop) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                if (!i_stat.can_inorder && !i_stat.can_force) begin
                    n_state = ST_IDLE;
                end else if (w_slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### verif/sequence_reorder_jitter_buffer_tb.sv
// one request as seen on the input channel
typedef struct packed {
    logic                                 req_type;
    logic [srjb_pkg::BYTES_W-1:0]         packet_bytes;
    logic [srjb_pkg::KIND_W-1:0]          packet_kind;
    srjb_pkg::t_seq                       seq_number;
    srjb_pkg::t_stamp                     stamp;
    srjb_pkg::t_tag                       payload_tag;
} t_pkt_item;

// one released descriptor
typedef struct packed {
    srjb_pkg::t_seq   seq;
    srjb_pkg::t_stamp stamp;
    srjb_pkg::t_tag   tag;
    logic             forced;
    logic             last_of_run;
} t_release;

class jitter_scoreboard;
    srjb_pkg::t_seq   held_seq_q[srjb_pkg::SLOTS];
    srjb_pkg::t_stamp held_stamp_q[srjb_pkg::SLOTS];
    srjb_pkg::t_tag   held_tag_q[srjb_pkg::SLOTS];
    int unsigned      fill;
    srjb_pkg::t_seq   last_seq;
    t_release         release_q[$];
    int unsigned      errors;

    function new();
        fill     = 0;
        last_seq = '0;
        errors   = 0;
    endfunction

    // take the head entry out of the sorted row
    function t_release pop_head(logic forced);
        t_release r;
        r.seq         = held_seq_q[0];
        r.stamp       = held_stamp_q[0];
        r.tag         = held_tag_q[0];
        r.forced      = forced;
        r.last_of_run = 1'b0;
        last_seq      = held_seq_q[0];
        for (int i = 1; i < fill; i++) begin
            held_seq_q[i-1]   = held_seq_q[i];
            held_stamp_q[i-1] = held_stamp_q[i];
            held_tag_q[i-1]   = held_tag_q[i];
        end
        fill--;
        return r;
    endfunction

    // predict the releases caused by one accepted item
    function void note_packet(t_pkt_item p);
        t_release burst[$];
        int       pos;
        if (p.req_type == srjb_pkg::REQ_RESTART) begin
            last_seq = '0;
            return;
        end
        if (p.packet_bytes < srjb_pkg::HEADER_BYTES ||
            p.packet_kind != srjb_pkg::KIND_AUDIO ||
            p.seq_number < last_seq)
            return;
        // sorted insert, ties stay behind earlier arrivals
        pos = fill;
        while (pos > 0 && held_seq_q[pos-1] > p.seq_number) begin
            held_seq_q[pos]   = held_seq_q[pos-1];
            held_stamp_q[pos] = held_stamp_q[pos-1];
            held_tag_q[pos]   = held_tag_q[pos-1];
            pos--;
        end
        held_seq_q[pos]   = p.seq_number;
        held_stamp_q[pos] = p.stamp;
        held_tag_q[pos]   = p.payload_tag;
        fill++;
        // in-order drain, then overflow flush
        while (fill > 0 && (last_seq == '0 ||
               held_seq_q[0] == srjb_pkg::t_seq'(last_seq + 1'b1)))
            burst = {burst, pop_head(1'b0)};
        while (fill > srjb_pkg::DEPTH)
            burst = {burst, pop_head(1'b1)};
        if (burst.size() > 0) begin
            burst[burst.size()-1].last_of_run = 1'b1;
            release_q = {release_q, burst};
        end
    endfunction

    function void check_release(t_release got);
        t_release want;
        if (release_q.size() == 0) begin
            $error("unexpected release: out_seq %0h", got.seq);
            errors++;
            return;
        end
        want = release_q[0];
        release_q.delete(0);
        if (got.seq !== want.seq) begin
            $error("out_seq: expected %0h, actual %0h", want.seq, got.seq);
            errors++;
        end
        if (got.stamp !== want.stamp) begin
            $error("out_stamp: expected %0h, actual %0h", want.stamp, got.stamp);
            errors++;
        end
        if (got.tag !== want.tag) begin
            $error("out_payload_tag: expected %0h, actual %0h", want.tag, got.tag);
            errors++;
        end
        if (got.forced !== want.forced) begin
            $error("forced: expected %0b, actual %0b", want.forced, got.forced);
            errors++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                   got.last_of_run);
            errors++;
        end
    endfunction
endclass

module sequence_reorder_jitter_buffer_tb;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    srjb_in_if  in_if ();
    srjb_out_if out_if ();

    sequence_reorder_jitter_buffer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    jitter_scoreboard sb;
    bit               idle_on  = 1'b1;
    bit               stall_on = 1'b1;
    int               stall_left = 0;
    t_release         seen_rel;
    t_pkt_item        seen_pkt;

    always #2 i_clk = ~i_clk;

    // receiver stalls at random, in bursts that stall_left counts down
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready = 1'b0;
            stall_left--;
        end else if (stall_on && $urandom_range(0, 4) == 0) begin
            out_if.ready = 1'b0;
            stall_left   = $urandom_range(0, 2);
        end else begin
            out_if.ready = 1'b1;
        end
    end

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                seen_rel.seq         = out_if.out_seq;
                seen_rel.stamp       = out_if.out_stamp;
                seen_rel.tag         = out_if.out_payload_tag;
                seen_rel.forced      = out_if.forced;
                seen_rel.last_of_run = out_if.last_of_run;
                sb.check_release(seen_rel);
            end
            if (in_if.valid && in_if.ready) begin
                seen_pkt.req_type     = in_if.req_type;
                seen_pkt.packet_bytes = in_if.packet_bytes;
                seen_pkt.packet_kind  = in_if.packet_kind;
                seen_pkt.seq_number   = in_if.seq_number;
                seen_pkt.stamp        = in_if.stamp;
                seen_pkt.payload_tag  = in_if.payload_tag;
                sb.note_packet(seen_pkt);
            end
        end
    end

    function automatic t_pkt_item make_pkt(logic [srjb_pkg::BYTES_W-1:0] bytes,
                                           logic [srjb_pkg::KIND_W-1:0] kind,
                                           srjb_pkg::t_seq seq,
                                           srjb_pkg::t_stamp stamp,
                                           srjb_pkg::t_tag tag);
        return '{srjb_pkg::REQ_PACKET, bytes, kind, seq, stamp, tag};
    endfunction

    // restart with junk in the other fields
    function automatic t_pkt_item make_restart();
        return '{srjb_pkg::REQ_RESTART, srjb_pkg::BYTES_W'($urandom),
                 srjb_pkg::KIND_W'($urandom), srjb_pkg::t_seq'($urandom),
                 srjb_pkg::t_stamp'($urandom), srjb_pkg::t_tag'($urandom)};
    endfunction

    // present one item, with an optional idle burst first
    task automatic send_item(input t_pkt_item p);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap         = $urandom_range(1, 3);
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        = 1'b1;
        in_if.req_type     = p.req_type;
        in_if.packet_bytes = p.packet_bytes;
        in_if.packet_kind  = p.packet_kind;
        in_if.seq_number   = p.seq_number;
        in_if.stamp        = p.stamp;
        in_if.payload_tag  = p.payload_tag;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_audio(input logic [srjb_pkg::BYTES_W-1:0] bytes,
                              input srjb_pkg::t_seq seq);
        send_item(make_pkt(bytes, srjb_pkg::KIND_AUDIO, seq, srjb_pkg::t_stamp'($urandom),
                           srjb_pkg::t_tag'($urandom)));
    endtask

    initial begin
        int                          roll;
        srjb_pkg::t_seq              next_seq;
        logic [srjb_pkg::KIND_W-1:0] bad_kind;

        sb = new();
        in_if.valid        = 1'b0;
        in_if.req_type     = srjb_pkg::REQ_PACKET;
        in_if.packet_bytes = '0;
        in_if.packet_kind  = '0;
        in_if.seq_number   = '0;
        in_if.stamp        = '0;
        in_if.payload_tag  = '0;
        out_if.ready       = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: drops, zero run, stale, equal, ties, flush, restart, wrap
        send_item(make_restart());
        send_audio(16'd15, 32'd10);
        send_audio(16'd0, 32'd10);
        send_item(make_pkt(16'd16, 8'h00, 32'd10, '0, '0));
        send_item(make_pkt(16'd16, 8'h02, 32'd10, '0, '0));
        send_item(make_pkt(16'd16, 8'hFF, 32'd10, '0, '0));
        send_item(make_pkt(16'd16, srjb_pkg::KIND_AUDIO, 32'd0, '0, '0));
        send_item(make_pkt(16'd16, srjb_pkg::KIND_AUDIO, 32'd0, '1, '1));
        send_audio(16'hFFFF, 32'd100);
        send_audio(16'd40, 32'd50);
        send_audio(16'd40, 32'd100);
        send_audio(16'd40, 32'd103);
        send_audio(16'd40, 32'd102);
        send_audio(16'd40, 32'd104);
        send_audio(16'd40, 32'd102);
        send_audio(16'd40, 32'd106);
        send_audio(16'd40, 32'd101);
        send_item(make_restart());
        send_item(make_pkt(16'd64, srjb_pkg::KIND_AUDIO, 32'hFFFF_FFFF, '1, '0));
        send_audio(16'd64, 32'd0);
        send_item(make_pkt(16'd64, srjb_pkg::KIND_AUDIO, 32'hFFFF_FFFF, '0, '1));
        send_item(make_restart());
        send_audio(16'd64, 32'd5);

        // random: mostly a jittered in-order stream, some noise and restarts
        next_seq = srjb_pkg::t_seq'($urandom);
        for (int n = 0; n < 207; n++) begin
            if (n == 170) begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                send_item(make_restart());
                next_seq = $urandom_range(0, 1) ? srjb_pkg::t_seq'($urandom) : 32'hFFFF_FFFA;
            end else if (roll < 12) begin
                send_audio(srjb_pkg::BYTES_W'($urandom_range(0, srjb_pkg::HEADER_BYTES - 1)),
                           next_seq);
            end else if (roll < 18) begin
                do bad_kind = srjb_pkg::KIND_W'($urandom);
                while (bad_kind == srjb_pkg::KIND_AUDIO);
                send_item(make_pkt(
                    srjb_pkg::BYTES_W'($urandom_range(srjb_pkg::HEADER_BYTES, 65535)),
                    bad_kind, next_seq, srjb_pkg::t_stamp'($urandom),
                    srjb_pkg::t_tag'($urandom)));
            end else if (roll < 22) begin
                send_audio(srjb_pkg::BYTES_W'($urandom_range(srjb_pkg::HEADER_BYTES, 65535)),
                           srjb_pkg::t_seq'($urandom));
            end else if (roll < 60) begin
                send_audio(srjb_pkg::BYTES_W'($urandom_range(srjb_pkg::HEADER_BYTES, 65535)),
                           next_seq);
                next_seq = next_seq + 1'b1;
            end else begin
                send_audio(srjb_pkg::BYTES_W'($urandom_range(srjb_pkg::HEADER_BYTES, 65535)),
                           srjb_pkg::t_seq'(next_seq + $urandom_range(0, 5) - 1));
            end
        end
        @(negedge i_clk);
        in_if.valid = 1'b0;

        // drain, then give a late stray result time to show
        while (sb.release_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** sequence_reorder_jitter_buffer: PASSED **");
        end else begin
            $display("** sequence_reorder_jitter_buffer: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("** sequence_reorder_jitter_buffer: FAILED **");
        $finish;
    end

endmodule
